// ===== rtl/ttw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text-mode terminal writer package
// Shared widths, codes, command kinds and the command word type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttw_pkg;

  localparam int DefCols = 80;
  localparam int DefRows = 25;

  localparam int OpW      = 3;
  localparam int CharW    = 8;
  localparam int ColW     = 7;
  localparam int RowW     = 5;
  localparam int ColorW   = 4;
  localparam int PosW     = 11;
  localparam int CellW    = 2 * ColorW + CharW;
  localparam int InDataW  = 32;
  localparam int OutDataW = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;
  localparam int QDepth   = 2;

  localparam logic [OpW-1:0] OpPutChar   = 3'd0;
  localparam logic [OpW-1:0] OpClear     = 3'd1;
  localparam logic [OpW-1:0] OpPaintCell = 3'd2;
  localparam logic [OpW-1:0] OpReadCell  = 3'd3;
  localparam logic [OpW-1:0] OpSetCursor = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgFgColor = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBgColor = 2'd1;

  localparam logic [CharW-1:0] ChNewline = 8'h0A;
  localparam logic [CharW-1:0] ChReturn  = 8'h0D;
  localparam logic [CharW-1:0] ChTab     = 8'h09;
  localparam logic [CharW-1:0] ChBlank   = 8'h20;
  localparam logic [CharW-1:0] ChLastPrt = 8'h7F;

  localparam logic [ColorW-1:0] ResetFg = 4'hF;
  localparam logic [ColorW-1:0] ResetBg = 4'h0;
  localparam logic [CellW-1:0]  ResetCell = {ResetBg, ResetFg, ChBlank};

  localparam int TabStep = 8;
  localparam logic [ColW:0] TabMask = 8'h07;

  typedef enum logic [3:0] {
    K_NOP,
    K_PUT,
    K_NEWLINE,
    K_RETURN,
    K_TAB,
    K_CLEAR,
    K_PAINT,
    K_READ,
    K_SETCUR
  } ttw_kind_e;

  typedef struct packed {
    ttw_kind_e           kind;
    logic [CharW-1:0]    char_code;
    logic [ColW-1:0]     col;
    logic [RowW-1:0]     row;
    logic [ColorW-1:0]   fg;
    logic [ColorW-1:0]   bg;
    logic                in_range;
  } ttw_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ttw_front.sv =====
// ----------------------------------------------------------------------------
// Terminal writer front end
// Accepts input words, decodes them into command kinds and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttw_front #(
  parameter int COLS = ttw_pkg::DefCols,
  parameter int ROWS = ttw_pkg::DefRows
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [ttw_pkg::InDataW-1:0]  s_axis_tdata,
  input  wire logic [ttw_pkg::OpW-1:0]      s_axis_tuser,
  input  wire logic                         init_done_i,
  output logic                              cmd_valid_o,
  input  wire logic                         cmd_ready_i,
  output ttw_pkg::ttw_cmd_t                 cmd_o
);
  import ttw_pkg::*;

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  ttw_cmd_t         q_mem_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  ttw_cmd_t         dec;
  logic [CharW-1:0] ch;
  logic             enq, deq;

  assign ch = s_axis_tdata[7:0];

  always_comb begin
    dec.char_code = ch;
    dec.col       = s_axis_tdata[14:8];
    dec.row       = s_axis_tdata[19:15];
    dec.fg        = s_axis_tdata[23:20];
    dec.bg        = s_axis_tdata[27:24];
    dec.in_range  = (dec.col < ColW'(COLS)) && (dec.row < RowW'(ROWS));
    case (s_axis_tuser)
      OpPutChar: begin
        if (ch == ChNewline) begin
          dec.kind = K_NEWLINE;
        end else if (ch == ChReturn) begin
          dec.kind = K_RETURN;
        end else if (ch == ChTab) begin
          dec.kind = K_TAB;
        end else if (ch inside {[ChBlank:ChLastPrt]}) begin
          dec.kind = K_PUT;
        end else begin
          dec.kind = K_NOP;
        end
      end
      OpClear:     dec.kind = K_CLEAR;
      OpPaintCell: dec.kind = K_PAINT;
      OpReadCell:  dec.kind = K_READ;
      OpSetCursor: dec.kind = K_SETCUR;
      default:     dec.kind = K_NOP;
    endcase
  end

  assign s_axis_tready = (count_q != CntW'(QDepth)) && init_done_i;
  assign enq           = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (count_q != '0);
  assign deq           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_mem_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (enq) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (deq) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (enq && !deq) begin
        count_q <= count_q + 1'b1;
      end else if (deq && !enq) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ttw_back.sv =====
// ----------------------------------------------------------------------------
// Terminal writer back end
// Executes queued commands on the cell store: writes, reads, cursor moves,
// screen fill and scroll sweeps, and holds the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttw_back #(
  parameter int COLS = ttw_pkg::DefCols,
  parameter int ROWS = ttw_pkg::DefRows
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  output logic                               cmd_ready_o,
  input  wire ttw_pkg::ttw_cmd_t             cmd_i,
  output logic                               init_done_o,
  input  wire logic                          cfg_valid_i,
  input  wire logic [ttw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [ttw_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [ttw_pkg::OutDataW-1:0]       m_axis_tdata
);
  import ttw_pkg::*;

  localparam int Cells = COLS * ROWS;
  localparam int AddrW = $clog2(Cells);

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_SCROLL,
    S_BLANK,
    S_DONE
  } state_e;

  logic [CellW-1:0] mem [Cells];
  logic [CellW-1:0] rd_data_q;

  state_e              state_q, state_d;
  logic [AddrW-1:0]    cnt_q, cnt_d;
  logic [ColW-1:0]     col_q, col_d;
  logic [RowW-1:0]     row_q, row_d;
  logic                init_q, init_d;
  logic                is_read_q, is_read_d;
  logic                copy_vld_q, copy_vld_d;
  logic [AddrW-1:0]    copy_addr_q, copy_addr_d;
  logic [ColorW-1:0]   fg_q, bg_q;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic                mem_we, mem_re;
  logic [AddrW-1:0]    mem_waddr, mem_raddr;
  logic [CellW-1:0]    mem_wdata;
  logic [AddrW-1:0]    cur_addr, cmd_addr;
  logic [ColW:0]       col_inc, tab_col;
  logic [RowW:0]       row_inc;
  logic                next_line;
  logic [CellW-1:0]    blank_cell, rd_cell;
  logic [PosW-1:0]     cur_pos;

  assign cur_addr   = AddrW'(row_q * COLS + col_q);
  assign cmd_addr   = AddrW'(cmd_i.row * COLS + cmd_i.col);
  assign cur_pos    = PosW'(row_q * COLS + col_q);
  assign col_inc    = {1'b0, col_q} + 1'b1;
  assign tab_col    = ({1'b0, col_q} + (ColW + 1)'(TabStep)) & ~TabMask;
  assign row_inc    = {1'b0, row_q} + 1'b1;
  assign blank_cell = {bg_q, fg_q, ChBlank};
  assign rd_cell    = is_read_q ? rd_data_q : '0;

  assign init_done_o   = !init_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    init_d      = init_q;
    is_read_d   = is_read_q;
    copy_vld_d  = 1'b0;
    copy_addr_d = copy_addr_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    cmd_ready_o = 1'b0;
    next_line   = 1'b0;
    case (state_q)
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = init_q ? ResetCell : blank_cell;
        if (cnt_q == AddrW'(Cells - 1)) begin
          if (init_q) begin
            init_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i && (!out_valid_q || m_axis_tready)) begin
          cmd_ready_o = 1'b1;
          is_read_d   = 1'b0;
          state_d     = S_DONE;
          case (cmd_i.kind)
            K_PUT: begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = {bg_q, fg_q, cmd_i.char_code};
              if (col_inc >= (ColW + 1)'(COLS)) begin
                next_line = 1'b1;
              end else begin
                col_d = col_inc[ColW-1:0];
              end
            end
            K_NEWLINE: next_line = 1'b1;
            K_RETURN:  col_d = '0;
            K_TAB: begin
              if (tab_col >= (ColW + 1)'(COLS)) begin
                next_line = 1'b1;
              end else begin
                col_d = tab_col[ColW-1:0];
              end
            end
            K_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              cnt_d   = '0;
              state_d = S_FILL;
            end
            K_PAINT: begin
              if (cmd_i.in_range) begin
                mem_we    = 1'b1;
                mem_waddr = cmd_addr;
                mem_wdata = {cmd_i.bg, cmd_i.fg, ChBlank};
              end
            end
            K_READ: begin
              if (cmd_i.in_range) begin
                mem_re    = 1'b1;
                mem_raddr = cmd_addr;
                is_read_d = 1'b1;
              end
            end
            K_SETCUR: begin
              if (cmd_i.in_range) begin
                col_d = cmd_i.col;
                row_d = cmd_i.row;
              end
            end
            default: ;
          endcase
          if (next_line) begin
            col_d = '0;
            if (row_inc >= (RowW + 1)'(ROWS)) begin
              row_d   = RowW'(ROWS - 1);
              cnt_d   = '0;
              state_d = S_SCROLL;
            end else begin
              row_d = row_inc[RowW-1:0];
            end
          end
        end
      end
      S_SCROLL: begin
        if (copy_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = copy_addr_q;
          mem_wdata = rd_data_q;
        end
        if (cnt_q < AddrW'(Cells - COLS)) begin
          mem_re      = 1'b1;
          mem_raddr   = cnt_q + AddrW'(COLS);
          copy_vld_d  = 1'b1;
          copy_addr_d = cnt_q;
          cnt_d       = cnt_q + 1'b1;
        end else begin
          state_d = S_BLANK;
        end
      end
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = blank_cell;
        if (cnt_q == AddrW'(Cells - 1)) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        out_data_d  = OutDataW'({rd_cell[15:8], rd_cell[7:0], cur_pos});
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      init_q      <= 1'b1;
      is_read_q   <= 1'b0;
      copy_vld_q  <= 1'b0;
      copy_addr_q <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      fg_q        <= ResetFg;
      bg_q        <= ResetBg;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      init_q      <= init_d;
      is_read_q   <= is_read_d;
      copy_vld_q  <= copy_vld_d;
      copy_addr_q <= copy_addr_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgFgColor: fg_q <= cfg_data_i;
          CfgBgColor: bg_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/text_mode_terminal_writer_top.sv =====
// ----------------------------------------------------------------------------
// Text-mode terminal writer
// A decoding front end with a two-word queue feeding a cell-store engine.
// ----------------------------------------------------------------------------
// An input word waits in the front-end queue, is taken by the back end when idle,
// and its result word is registered in the done state. The back end takes the next
// command only after that; the queue holds further words meanwhile. Clear screen
// runs a fill pass and a scroll a copy sweep and a last-row blank, both set by the
// single write port of the cell store. A reset fill pass holds s_axis_tready low.
`timescale 1ns / 1ps
`default_nettype none

module text_mode_terminal_writer_top #(
  parameter int COLS = ttw_pkg::DefCols,
  parameter int ROWS = ttw_pkg::DefRows
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // char_code[7:0], col[14:8], row[19:15], fg[23:20], bg[27:24], zero pad
  input  wire logic [ttw_pkg::InDataW-1:0]   s_axis_tdata,
  // operation[2:0]
  input  wire logic [ttw_pkg::OpW-1:0]       s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // cursor_pos[10:0], cell_char[18:11], cell_color[26:19], zero pad
  output logic [ttw_pkg::OutDataW-1:0]       m_axis_tdata,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ttw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [ttw_pkg::CfgDataW-1:0]  cfg_data_i
);
  import ttw_pkg::*;

  ttw_cmd_t cmd;
  logic     cmd_valid, cmd_ready, init_done;

  assign cfg_ready_o = 1'b1;

  ttw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .init_done_i   (init_done),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  ttw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .init_done_o   (init_done),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire
